// ----- hdl/psec_pkg.sv -----
// Package for the per-sender event counter: sizes, event codes, shared types.
// Used by psec_front, psec_back and the top level; depends on nothing.
package psec_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ID_W        = 22;
    localparam int CNT_W       = 32;
    localparam int CMD_W       = 2;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    typedef enum logic [1:0] {
        K_A,
        K_B,
        K_STOP,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] sid;
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_CNT,
        S_OUT
    } t_bstate;

endpackage

// ----- hdl/psec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/psec_front.sv -----
// Front end: takes event transactions, decodes the kind, queues them.
// Depends on psec_pkg.
module psec_front
    import psec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [ID_W-1:0]  i_sender_id,
    output logic             o_op_valid,
    output t_op              o_op,
    input  logic             i_op_pop
);

    t_op               r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_kind             kind;

    always_comb begin
        unique case (i_cmd)
            CMD_A:    kind = K_A;
            CMD_B:    kind = K_B;
            CMD_STOP: kind = K_STOP;
            default:  kind = K_NONE;
        endcase
    end

    assign o_stall    = (r_cnt == QCNT_W'(QDEPTH));
    assign push       = i_valid && !o_stall;
    assign o_op_valid = (r_cnt != '0);
    assign pop        = i_op_pop && o_op_valid;
    assign o_op       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= '{kind: kind, sid: i_sender_id};
        end
    end

endmodule

// ----- hdl/psec_back.sv -----
// Back end: table search, entry append, count update, result register.
// Depends on psec_pkg and psec_ram.
module psec_back
    import psec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    input  t_op              i_op,
    output logic             o_op_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ID_W-1:0]  o_entry_id,
    output logic [CNT_W-1:0] o_count_a,
    output logic [CNT_W-1:0] o_count_b,
    output logic             o_table_full,
    output logic             o_stop_seen
);

    t_bstate           r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [ID_W-1:0]   r_sid, n_sid;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [USED_W-1:0] r_used, n_used;
    logic              r_stop, n_stop;
    logic [CNT_W-1:0]  r_res_a, n_res_a;
    logic [CNT_W-1:0]  r_res_b, n_res_b;
    logic              r_res_full, n_res_full;
    logic              r_ov, n_ov;
    logic [ID_W-1:0]   r_oid, n_oid;
    logic [CNT_W-1:0]  r_oa, n_oa;
    logic [CNT_W-1:0]  r_ob, n_ob;
    logic              r_ofull, n_ofull;
    logic              r_ostop, n_ostop;

    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [IDX_W-1:0]       raddr;
    logic [ID_W-1:0]        id_rdata;
    logic [2*CNT_W-1:0]     cnt_wdata;
    logic [2*CNT_W-1:0]     cnt_rdata;
    logic [CNT_W-1:0]       cur_a;
    logic [CNT_W-1:0]       cur_b;
    logic [CNT_W-1:0]       upd_a;
    logic [CNT_W-1:0]       upd_b;
    logic                   last;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    psec_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_sid),
        .i_raddr (raddr),
        .o_rdata (id_rdata)
    );

    psec_ram #(.WIDTH(2*CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (raddr),
        .o_rdata (cnt_rdata)
    );

    // fresh entry starts from zero, a hit starts from the stored counts
    assign cur_a     = (r_state == S_MISS) ? '0 : cnt_rdata[2*CNT_W-1:CNT_W];
    assign cur_b     = (r_state == S_MISS) ? '0 : cnt_rdata[CNT_W-1:0];
    assign upd_a     = (r_kind == K_A) ? sat_inc(cur_a) : cur_a;
    assign upd_b     = (r_kind == K_B) ? sat_inc(cur_b) : cur_b;
    assign cnt_wdata = {upd_a, upd_b};
    assign waddr     = (r_state == S_MISS) ? IDX_W'(r_used) : r_idx;
    assign last      = (USED_W'(r_idx) + USED_W'(1) == r_used);

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_sid      = r_sid;
        n_idx      = r_idx;
        n_used     = r_used;
        n_stop     = r_stop;
        n_res_a    = r_res_a;
        n_res_b    = r_res_b;
        n_res_full = r_res_full;
        n_ov       = r_ov && i_stall;
        n_oid      = r_oid;
        n_oa       = r_oa;
        n_ob       = r_ob;
        n_ofull    = r_ofull;
        n_ostop    = r_ostop;
        o_op_pop   = 1'b0;
        we         = 1'b0;
        raddr      = r_idx;

        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    n_kind   = i_op.kind;
                    n_sid    = i_op.sid;
                    n_stop   = r_stop || (i_op.kind == K_STOP);
                    n_idx    = '0;
                    n_state  = (r_used == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (id_rdata == r_sid) begin
                    n_state = S_CNT;
                end else if (last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                    raddr = n_idx;
                end
            end
            S_MISS: begin
                if (r_used == USED_W'(TABLE_DEPTH)) begin
                    n_res_a    = '0;
                    n_res_b    = '0;
                    n_res_full = 1'b1;
                end else begin
                    we         = 1'b1;
                    n_used     = r_used + USED_W'(1);
                    n_res_a    = upd_a;
                    n_res_b    = upd_b;
                    n_res_full = 1'b0;
                end
                n_state = S_OUT;
            end
            S_CNT: begin
                we         = 1'b1;
                n_res_a    = upd_a;
                n_res_b    = upd_b;
                n_res_full = 1'b0;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_oid   = r_sid;
                    n_oa    = r_res_a;
                    n_ob    = r_res_b;
                    n_ofull = r_res_full;
                    n_ostop = r_stop;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_stop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_stop  <= n_stop;
            r_ov    <= n_ov;
        end
        r_kind     <= n_kind;
        r_sid      <= n_sid;
        r_idx      <= n_idx;
        r_res_a    <= n_res_a;
        r_res_b    <= n_res_b;
        r_res_full <= n_res_full;
        r_oid      <= n_oid;
        r_oa       <= n_oa;
        r_ob       <= n_ob;
        r_ofull    <= n_ofull;
        r_ostop    <= n_ostop;
    end

    assign o_valid      = r_ov;
    assign o_entry_id   = r_oid;
    assign o_count_a    = r_oa;
    assign o_count_b    = r_ob;
    assign o_table_full = r_ofull;
    assign o_stop_seen  = r_ostop;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (USED_W'(r_idx) < r_used))
        else $error("search index past last valid entry");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop && i_rst_n) |=> r_stop)
        else $error("stop flag cleared without reset");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofull) |-> (r_oa == '0 && r_ob == '0))
        else $error("full-table result carries counts");

    a_write_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_MISS || r_state == S_CNT))
        else $error("table write outside update step");

endmodule

// ----- hdl/per_sender_event_counter_core.sv -----
// Top level of the per-sender event counter: front end, queue, back end.
// Depends on psec_pkg, psec_front, psec_back (and psec_ram through psec_back).
//
// Channel   Dir  Valid     Stall     Payload
// -------   ---  --------  --------  ---------------------------------------------
// event     in   i_valid   o_stall   i_cmd, i_sender_id
// result    out  o_valid   i_stall   o_entry_id, o_count_a, o_count_b,
//                                    o_table_full, o_stop_seen
//
// Search: an event is searched one table entry per cycle through the id RAM
//   read port. A hit goes on to the count update; a miss appends an entry, or
//   flags a full table; either then loads the result register.
// The two-deep queue takes new transactions while the back end searches, and
//   the back end keeps searching while a result waits in the output register.
// Reset (synchronous, active low) empties the queue, the entry count, the stop
//   flag and the output register; the RAM contents are not cleared, as only
//   entries below the entry count are ever read.
// o_stall rises only when the queue is full; i_stall holds the result stage.
module per_sender_event_counter_core
    import psec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [ID_W-1:0]  i_sender_id,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ID_W-1:0]  o_entry_id,
    output logic [CNT_W-1:0] o_count_a,
    output logic [CNT_W-1:0] o_count_b,
    output logic             o_table_full,
    output logic             o_stop_seen
);

    // decoded events between the two halves
    logic op_valid;
    logic op_pop;
    t_op  op;

    // front end: accept, decode the kind, queue
    psec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_sender_id (i_sender_id),
        .o_op_valid  (op_valid),
        .o_op        (op),
        .i_op_pop    (op_pop)
    );

    // back end: linear search, append on miss, saturating count update
    psec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (op_valid),
        .i_op         (op),
        .o_op_pop     (op_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_entry_id   (o_entry_id),
        .o_count_a    (o_count_a),
        .o_count_b    (o_count_b),
        .o_table_full (o_table_full),
        .o_stop_seen  (o_stop_seen)
    );

endmodule

// ----- dv/per_sender_event_counter_core_tb.sv -----
// Testbench for per_sender_event_counter_core: drives event transactions, predicts every result.
// Depends on psec_pkg and the core RTL only; needs no files or arguments.
`timescale 1ns / 1ps

module per_sender_event_counter_core_tb;
    import psec_pkg::*;

    localparam int EVENT_TARGET = 1600;   // rough number of event transactions to post
    localparam int IDLE_LIMIT   = 4000;   // cycles with no transaction before giving up
    localparam int PRINT_CAP    = 200;    // mismatch lines printed before going quiet

    // Expected result of one event, field for field as on the result channel.
    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic             table_full;
        logic             stop_seen;
    } t_tally;

    // DUT ports; the inputs are known from time zero.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [CMD_W-1:0] i_cmd       = '0;
    logic [ID_W-1:0]  i_sender_id = '0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [ID_W-1:0]  o_entry_id;
    logic [CNT_W-1:0] o_count_a;
    logic [CNT_W-1:0] o_count_b;
    logic             o_table_full;
    logic             o_stop_seen;

    per_sender_event_counter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_sender_id  (i_sender_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_entry_id   (o_entry_id),
        .o_count_a    (o_count_a),
        .o_count_b    (o_count_b),
        .o_table_full (o_table_full),
        .o_stop_seen  (o_stop_seen)
    );

    // 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender table mirror. Only slots below senders_known are ever read,
    // so the arrays need no reset of their own.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]  sender_tab [TABLE_DEPTH];
    logic [CNT_W-1:0] a_tally    [TABLE_DEPTH];
    logic [CNT_W-1:0] b_tally    [TABLE_DEPTH];
    int               senders_known = 0;
    bit               stop_latched  = 1'b0;
    t_tally           pending_tallies [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int events_sent   = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int stall_run     = 0;
    int stall_mode    = 0;

    // Entry order search, first match wins; -1 on a miss.
    function automatic int lookup_sender(logic [ID_W-1:0] sid);
        for (int i = 0; i < senders_known; i++) begin
            if (sender_tab[i] == sid) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Work out the result of one accepted event and queue it.
    task automatic tally_event(t_kind kind, logic [ID_W-1:0] sid);
        int     slot;
        t_tally t;
        slot = lookup_sender(sid);
        // Miss with room left: append a fresh entry, counts at zero.
        if (slot < 0 && senders_known < TABLE_DEPTH) begin
            slot             = senders_known;
            sender_tab[slot] = sid;
            a_tally[slot]    = '0;
            b_tally[slot]    = '0;
            senders_known++;
        end
        // Stop is sticky and is taken even when the table is full.
        if (kind == K_STOP) begin
            stop_latched = 1'b1;
        end
        if (slot < 0) begin
            // Table full: echo the id, no counting.
            t = '{entry_id: sid, count_a: '0, count_b: '0,
                  table_full: 1'b1, stop_seen: stop_latched};
        end else begin
            if (kind == K_A && a_tally[slot] != '1) begin
                a_tally[slot]++;
            end
            if (kind == K_B && b_tally[slot] != '1) begin
                b_tally[slot]++;
            end
            t = '{entry_id: sender_tab[slot], count_a: a_tally[slot],
                  count_b: b_tally[slot], table_full: 1'b0, stop_seen: stop_latched};
        end
        pending_tallies.push_back(t);
    endtask

    // ------------------------------------------------------------------
    // Event transaction driver: bursts of random length, random gaps
    // between them, and now and then no gap at all. Valid stays high
    // from one transaction to the next inside a burst.
    // ------------------------------------------------------------------
    task automatic post_event(t_kind kind, logic [ID_W-1:0] sid);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_cmd       <= kind;
        i_sender_id <= sid;
        do @(posedge i_clk); while (o_stall);
        events_sent++;
        tally_event(kind, sid);
    endtask

    function automatic t_kind random_kind(bit with_stop);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return K_A;
        end
        if (r < 8) begin
            return K_B;
        end
        if (r == 8 || !with_stop) begin
            return K_NONE;
        end
        return K_STOP;
    endfunction

    function automatic logic [ID_W-1:0] known_sender();
        return sender_tab[$urandom_range(0, senders_known - 1)];
    endfunction

    function automatic logic [ID_W-1:0] unknown_sender();
        logic [ID_W-1:0] sid;
        do sid = ID_W'($urandom_range(0, (1 << ID_W) - 1)); while (lookup_sender(sid) >= 0);
        return sid;
    endfunction

    // ------------------------------------------------------------------
    // Result side: the receiver stalls on its own pattern, runs of
    // random length that are clear, light, half or heavy.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(8, 64);
            i_stall    <= 1'b0;
        end else begin
            stall_run <= stall_run - 1;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= 1'($urandom_range(0, 1));
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
        end
    endtask

    // Each result transaction against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_tally want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tallies.size() == 0) begin
                flag_mismatch("result with no event waiting for it");
            end else begin
                want = pending_tallies.pop_front();
                check_field("entry_id", CNT_W'(o_entry_id), CNT_W'(want.entry_id));
                check_field("count_a", o_count_a, want.count_a);
                check_field("count_b", o_count_b, want.count_b);
                check_field("table_full", CNT_W'(o_table_full), CNT_W'(want.table_full));
                check_field("stop_seen", CNT_W'(o_stop_seen), CNT_W'(want.stop_seen));
            end
            results_seen++;
        end
    end

    // Watchdog: a full-table miss is the slowest search, well under the limit.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Each kind on fresh and known senders, id extremes, stop held back.
    task automatic test_entry_kinds();
        post_event(K_A,    '0);
        post_event(K_B,    '0);
        post_event(K_NONE, '1);        // unused kind still enters the sender
        post_event(K_A,    '1);
        post_event(K_B,    '1);
        post_event(K_B,    '1);
        post_event(K_A,    '0);
        post_event(K_NONE, '0);        // counts must not move
        post_event(K_A,    22'h2AAAAA);
        post_event(K_B,    22'h155555);
        post_event(K_B,    22'h2AAAAA);
    endtask

    // Random traffic while the table grows to one short of full; no stop yet.
    task automatic test_table_fill();
        while (senders_known < TABLE_DEPTH - 1) begin
            if ($urandom_range(0, 1) == 0) begin
                post_event(random_kind(1'b0), known_sender());
            end else begin
                post_event(random_kind(1'b0), ID_W'($urandom_range(0, (1 << ID_W) - 1)));
            end
        end
    endtask

    // Last free entry, then misses on a full table; first stop arrives on one.
    task automatic test_table_full();
        post_event(K_B,    unknown_sender());   // takes the last entry
        post_event(K_A,    unknown_sender());   // full, stop still clear
        post_event(K_NONE, unknown_sender());
        post_event(K_STOP, unknown_sender());   // full, but stop must latch
        post_event(K_A,    unknown_sender());
        post_event(K_STOP, sender_tab[TABLE_DEPTH - 1]);
        post_event(K_B,    sender_tab[0]);
        post_event(K_NONE, sender_tab[TABLE_DEPTH - 1]);
    endtask

    // Bulk of the run: mostly known senders at every depth, plus misses.
    task automatic test_random_traffic();
        while (events_sent < EVENT_TARGET) begin
            if ($urandom_range(0, 99) < 65) begin
                post_event(random_kind(1'b1), known_sender());
            end else begin
                post_event(random_kind(1'b1), unknown_sender());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_entry_kinds();
        test_table_fill();
        test_table_full();
        test_random_traffic();
        i_valid <= 1'b0;

        // Drain, then keep the clock running so that any stray result
        // would show up.
        while (pending_tallies.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
